// ===== rtl/mwm_pkg.sv =====
// Shared types, constants and a lookup function for the mecanum wheel mixer.
package mwm_pkg;

  localparam int unsigned WHEEL_COUNT  = 4;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_STEPS    = 15;

  // Binary-angle fold limits.
  localparam logic signed [17:0] QUARTER_TURN = 18'sd16384;
  localparam logic signed [17:0] HALF_TURN    = 18'sd32768;

  // CORDIC gain compensation, Q30.
  localparam logic signed [30:0] CORDIC_GAIN = 31'sd652032874;

  // 1.0 in the internal Q.27 scale.
  localparam logic [31:0] ONE_INTERNAL = 32'd134217728;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [17:0] ang;
    logic signed [15:0] rot;
  } cordic_t;

  typedef struct packed {
    logic [31:0]                       maxm;
    logic                              scaled;
    logic [WHEEL_COUNT-1:0]            neg;
    logic [WHEEL_COUNT-1:0][14:0]      plain;
    logic [WHEEL_COUNT-1:0][31:0]      rem;
    logic [WHEEL_COUNT-1:0][14:0]      nlow;
    logic [WHEEL_COUNT-1:0][14:0]      quo;
  } div_t;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic signed [17:0] atan_lut(input logic [3:0] step);
    logic signed [17:0] r;
    case (step)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      4'd14:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mecanum_wheel_mixer.sv =====
// Top level of the mecanum wheel mixer: fold, CORDIC chain, mixing, desaturation.
//
// Usage: one drive command transfers on the input channel (in_valid_i/in_ready_o)
// and yields exactly one result transfer on the output channel
// (out_valid_o/out_ready_i): four Q1.14 wheel setpoints and was_scaled_o.
// Cartesian commands are rotated by minus the gyro heading; polar commands
// rotate (radius, 0) by theta. The mixed wheels are divided by their largest
// magnitude when it exceeds 1.0.
// Pipeline: 1 fold register, 16 CORDIC cells, 2 gain stages, mix, magnitude,
// maximum, numerator, 15 divider cells, output register. Throughput: one
// command per cycle while the output is not stalled; the whole chain is a
// single pipeline that advances together.
// Stall: when a result waits in the output register and out_ready_i is low,
// the chain holds and in_ready_o drops; nothing is lost.
// Reset: rst_ni clears all valid bits; payload registers are not reset.
module mecanum_wheel_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [15:0] x_cmd_i,
  input  logic signed [15:0] y_cmd_i,
  input  logic signed [15:0] radius_cmd_i,
  input  logic [15:0]        theta_angle_i,
  input  logic signed [15:0] rotation_cmd_i,
  input  logic [15:0]        gyro_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] front_left_speed_o,
  output logic signed [15:0] front_right_speed_o,
  output logic signed [15:0] rear_left_speed_o,
  output logic signed [15:0] rear_right_speed_o,
  output logic               was_scaled_o
);

  localparam int unsigned NW = mwm_pkg::WHEEL_COUNT;

  // Advance the whole chain whenever the output register is free or drains.
  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- fold stage ----------------
  logic               fold_vld_q;
  mwm_pkg::cordic_t   fold_d, fold_q;
  logic signed [33:0] x0, y0;
  logic [15:0]        ang_raw;
  logic signed [17:0] ang0;

  always_comb begin
    if (operation_i) begin
      x0      = 34'($signed({radius_cmd_i, 14'b0}));
      y0      = '0;
      ang_raw = theta_angle_i;
    end else begin
      x0      = 34'($signed({x_cmd_i, 14'b0}));
      y0      = 34'($signed({y_cmd_i, 14'b0}));
      ang_raw = 16'(16'd0 - gyro_angle_i);
    end
    ang0       = 18'($signed(ang_raw));
    fold_d.rot = rotation_cmd_i;
    fold_d.x   = x0;
    fold_d.y   = y0;
    fold_d.ang = ang0;
    // Angles beyond a quarter turn: negate the vector, shift by a half turn.
    if (ang0 > mwm_pkg::QUARTER_TURN) begin
      fold_d.x   = -x0;
      fold_d.y   = -y0;
      fold_d.ang = ang0 - mwm_pkg::HALF_TURN;
    end else if (ang0 < -mwm_pkg::QUARTER_TURN) begin
      fold_d.x   = -x0;
      fold_d.y   = -y0;
      fold_d.ang = ang0 + mwm_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
    end else if (adv) begin
      fold_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fold_q <= fold_d;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic             cv [mwm_pkg::CORDIC_STEPS+1];
  mwm_pkg::cordic_t cd [mwm_pkg::CORDIC_STEPS+1];

  assign cv[0] = fold_vld_q;
  assign cd[0] = fold_q;

  for (genvar i = 0; i < mwm_pkg::CORDIC_STEPS; i++) begin : g_cordic
    mwm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .step_i (4'(i)),
      .vld_i  (cv[i]),
      .d_i    (cd[i]),
      .vld_o  (cv[i+1]),
      .q_o    (cd[i+1])
    );
  end

  mwm_pkg::cordic_t cend;
  logic             cend_vld;
  assign cend     = cd[mwm_pkg::CORDIC_STEPS];
  assign cend_vld = cv[mwm_pkg::CORDIC_STEPS];

  // ---------------- gain stage A: split partial products ----------------
  logic               ga_vld_q;
  logic signed [47:0] pxh_q, pxl_q, pyh_q, pyl_q;
  logic signed [15:0] ga_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ga_vld_q <= 1'b0;
    end else if (adv) begin
      ga_vld_q <= cend_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxh_q    <= $signed(cend.x[33:17]) * mwm_pkg::CORDIC_GAIN;
      pxl_q    <= $signed({1'b0, cend.x[16:0]}) * mwm_pkg::CORDIC_GAIN;
      pyh_q    <= $signed(cend.y[33:17]) * mwm_pkg::CORDIC_GAIN;
      pyl_q    <= $signed({1'b0, cend.y[16:0]}) * mwm_pkg::CORDIC_GAIN;
      ga_rot_q <= cend.rot;
    end
  end

  // ---------------- gain stage B: recombine and round ----------------
  logic               gb_vld_q;
  logic signed [65:0] sx, sy;
  logic signed [31:0] vx_q, vy_q;
  logic signed [15:0] gb_rot_q;

  always_comb begin
    sx = (66'(pxh_q) <<< 17) + 66'(pxl_q) + (66'sd1 <<< 29);
    sy = (66'(pyh_q) <<< 17) + 66'(pyl_q) + (66'sd1 <<< 29);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_vld_q <= 1'b0;
    end else if (adv) begin
      gb_vld_q <= ga_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vx_q     <= sx[61:30];
      vy_q     <= sy[61:30];
      gb_rot_q <= ga_rot_q;
    end
  end

  // ---------------- mix stage ----------------
  logic               mx_vld_q;
  logic signed [32:0] ex, ey, ez;
  logic signed [32:0] wh_d [NW];
  logic signed [32:0] wh_q [NW];

  always_comb begin
    ex = 33'(vx_q);
    ey = 33'(vy_q);
    ez = 33'($signed({gb_rot_q, 14'b0}));
    wh_d[0] = ex + ey + ez;
    wh_d[1] = ey - ex - ez;
    wh_d[2] = ey - ex + ez;
    wh_d[3] = ex + ey - ez;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx_vld_q <= 1'b0;
    end else if (adv) begin
      mx_vld_q <= gb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wh_q <= wh_d;
    end
  end

  // ---------------- magnitude stage ----------------
  logic                 mg_vld_q;
  logic [31:0]          mag_d [NW];
  logic [31:0]          mag_q [NW];
  logic [32:0]          rnd [NW];
  logic [NW-1:0]        neg_d, neg_q;
  logic [NW-1:0][14:0]  plain_d, plain_q;
  logic [31:0]          m01_q, m23_q;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      neg_d[w]   = wh_q[w][32];
      mag_d[w]   = neg_d[w] ? 32'(-wh_q[w]) : wh_q[w][31:0];
      rnd[w]     = {1'b0, mag_d[w]} + 33'd4096;
      plain_d[w] = rnd[w][27:13];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_vld_q <= 1'b0;
    end else if (adv) begin
      mg_vld_q <= mx_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      plain_q <= plain_d;
      m01_q   <= (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
      m23_q   <= (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
    end
  end

  // ---------------- maximum stage ----------------
  logic                mm_vld_q;
  logic [31:0]         maxm_d, maxm_q;
  logic [31:0]         mm_mag_q [NW];
  logic [NW-1:0]       mm_neg_q;
  logic [NW-1:0][14:0] mm_plain_q;
  logic                scaled_q;

  assign maxm_d = (m01_q > m23_q) ? m01_q : m23_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_vld_q <= 1'b0;
    end else if (adv) begin
      mm_vld_q <= mg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      maxm_q     <= maxm_d;
      scaled_q   <= maxm_d > mwm_pkg::ONE_INTERNAL;
      mm_mag_q   <= mag_q;
      mm_neg_q   <= neg_q;
      mm_plain_q <= plain_q;
    end
  end

  // ---------------- numerator stage: mag*2^14 + max/2 ----------------
  logic          nm_vld_q;
  mwm_pkg::div_t nm_d, nm_q;
  logic [46:0]   numer [NW];

  always_comb begin
    nm_d.maxm   = maxm_q;
    nm_d.scaled = scaled_q;
    nm_d.neg    = mm_neg_q;
    nm_d.plain  = mm_plain_q;
    for (int w = 0; w < NW; w++) begin
      numer[w]     = {1'b0, mm_mag_q[w], 14'b0} + 47'(maxm_q >> 1);
      nm_d.rem[w]  = numer[w][46:15];
      nm_d.nlow[w] = numer[w][14:0];
      nm_d.quo[w]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm_vld_q <= 1'b0;
    end else if (adv) begin
      nm_vld_q <= mm_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_q <= nm_d;
    end
  end

  // ---------------- divider chain ----------------
  logic          dv [mwm_pkg::DIV_STEPS+1];
  mwm_pkg::div_t dd [mwm_pkg::DIV_STEPS+1];

  assign dv[0] = nm_vld_q;
  assign dd[0] = nm_q;

  for (genvar k = 0; k < mwm_pkg::DIV_STEPS; k++) begin : g_div
    mwm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dv[k]),
      .d_i    (dd[k]),
      .vld_o  (dv[k+1]),
      .q_o    (dd[k+1])
    );
  end

  mwm_pkg::div_t dend;
  assign dend = dd[mwm_pkg::DIV_STEPS];

  // ---------------- output register ----------------
  logic [14:0]        qsel [NW];
  logic signed [15:0] spd_d [NW];
  logic signed [15:0] spd_q [NW];
  logic               scl_q;

  always_comb begin
    for (int w = 0; w < NW; w++) begin
      qsel[w]  = dend.scaled ? dend.quo[w] : dend.plain[w];
      spd_d[w] = dend.neg[w] ? -$signed({1'b0, qsel[w]}) : $signed({1'b0, qsel[w]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv[mwm_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spd_q <= spd_d;
      scl_q <= dend.scaled;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign front_left_speed_o  = spd_q[0];
  assign front_right_speed_o = spd_q[1];
  assign rear_left_speed_o   = spd_q[2];
  assign rear_right_speed_o  = spd_q[3];
  assign was_scaled_o        = scl_q;

endmodule

// ===== rtl/mwm_cordic_cell.sv =====
// One CORDIC rotation stage with its pipeline register.
module mwm_cordic_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [3:0]       step_i,
  input  logic             vld_i,
  input  mwm_pkg::cordic_t d_i,
  output logic             vld_o,
  output mwm_pkg::cordic_t q_o
);

  logic             vld_q;
  mwm_pkg::cordic_t dat_d, dat_q;
  logic signed [33:0] dx, dy;

  always_comb begin
    dx    = d_i.y >>> step_i;
    dy    = d_i.x >>> step_i;
    dat_d = d_i;
    if (d_i.ang >= 18'sd0) begin
      dat_d.x   = d_i.x - dx;
      dat_d.y   = d_i.y + dy;
      dat_d.ang = d_i.ang - mwm_pkg::atan_lut(step_i);
    end else begin
      dat_d.x   = d_i.x + dx;
      dat_d.y   = d_i.y - dy;
      dat_d.ang = d_i.ang + mwm_pkg::atan_lut(step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = dat_q;

endmodule

// ===== rtl/mwm_div_cell.sv =====
// One restoring-division stage: one quotient bit for every wheel.
module mwm_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  mwm_pkg::div_t d_i,
  output logic          vld_o,
  output mwm_pkg::div_t q_o
);

  logic          vld_q;
  mwm_pkg::div_t dat_d, dat_q;
  logic [32:0]   rem_sh [mwm_pkg::WHEEL_COUNT];
  logic [32:0]   rem_sub [mwm_pkg::WHEEL_COUNT];
  logic [mwm_pkg::WHEEL_COUNT-1:0] ge;

  always_comb begin
    dat_d = d_i;
    for (int w = 0; w < mwm_pkg::WHEEL_COUNT; w++) begin
      rem_sh[w]  = {d_i.rem[w], d_i.nlow[w][14]};
      rem_sub[w] = rem_sh[w] - {1'b0, d_i.maxm};
      ge[w]      = rem_sh[w] >= {1'b0, d_i.maxm};
      dat_d.rem[w]  = ge[w] ? rem_sub[w][31:0] : rem_sh[w][31:0];
      dat_d.quo[w]  = {d_i.quo[w][13:0], ge[w]};
      dat_d.nlow[w] = {d_i.nlow[w][13:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = dat_q;

endmodule

// ===== test/tb_mecanum_wheel_mixer.sv =====
// Self-checking testbench for the mecanum wheel mixer: directed table, then random commands.
`timescale 1ns / 100ps

module tb_mecanum_wheel_mixer;

  localparam int N_RANDOM     = 1730;
  localparam int QUIET_FROM   = 1450;  // no idling from this random item on
  localparam int PRESS_AT     = 300;   // random item where the long receiver hold starts
  localparam int PRESS_CYCLES = 250;
  localparam int WATCHDOG     = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic OP_CART  = 1'b0;
  localparam logic OP_POLAR = 1'b1;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ONE_Q27  = 64'sd134217728;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] radius;
    logic [15:0]        theta;
    logic signed [15:0] rot;
    logic [15:0]        gyro;
  } drive_cmd_t;

  typedef struct packed {
    logic signed [15:0] fl;
    logic signed [15:0] fr;
    logic signed [15:0] rl;
    logic signed [15:0] rr;
    logic               scaled;
  } wheel_set_t;

  typedef struct packed {
    drive_cmd_t cmd;
    logic       typed;   // expected result written into the row
    wheel_set_t want;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic operation_i;
  logic signed [15:0] x_cmd_i, y_cmd_i, radius_cmd_i, rotation_cmd_i;
  logic [15:0] theta_angle_i, gyro_angle_i;
  logic out_valid_o, out_ready_i;
  logic signed [15:0] front_left_speed_o, front_right_speed_o;
  logic signed [15:0] rear_left_speed_o, rear_right_speed_o;
  logic was_scaled_o;

  mecanum_wheel_mixer dut (.*);

  wheel_set_t wheel_queue[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;        // idling off in the last part of the run
  bit  press_req = 0;    // ask the receiver for the long hold

  longint steer_atan[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                             41, 20, 10, 5, 3, 1, 1, 0};

  // Rotate a Q.27 vector counterclockwise by a binary angle, CORDIC style.
  function automatic void cordic_turn(inout longint vx, inout longint vy,
                                      input int unsigned ang);
    longint a, dx, dy;
    a = ang & 16'hFFFF;
    if (a >= 32768) a -= 65536;
    // fold into -90..90 by negating the vector
    if (a > 16384) begin
      vx = -vx; vy = -vy; a -= 32768;
    end else if (a < -16384) begin
      vx = -vx; vy = -vy; a += 32768;
    end
    for (int i = 0; i < 16; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (a >= 0) begin
        vx -= dx; vy += dy; a -= steer_atan[i];
      end else begin
        vx += dx; vy -= dy; a += steer_atan[i];
      end
    end
    vx = (vx * GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
    vy = (vy * GAIN_Q30 + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Mix the command into four wheel setpoints and desaturate.
  function automatic wheel_set_t mix_wheels(input drive_cmd_t c);
    longint vx, vy, z, m, mag, q;
    longint w[4];
    wheel_set_t r;
    logic signed [15:0] s[4];
    if (c.op == OP_POLAR) begin
      vx = longint'(c.radius) <<< 14;
      vy = 0;
      cordic_turn(vx, vy, c.theta);
    end else begin
      vx = longint'(c.x) <<< 14;
      vy = longint'(c.y) <<< 14;
      cordic_turn(vx, vy, (65536 - c.gyro) & 16'hFFFF);
    end
    z = longint'(c.rot) <<< 14;
    w[0] = vx + vy + z;
    w[1] = -vx + vy - z;
    w[2] = -vx + vy + z;
    w[3] = vx + vy - z;
    m = 0;
    foreach (w[i]) if ((w[i] < 0 ? -w[i] : w[i]) > m) m = (w[i] < 0 ? -w[i] : w[i]);
    r.scaled = (m > ONE_Q27);
    foreach (w[i]) begin
      mag = w[i] < 0 ? -w[i] : w[i];
      if (r.scaled) q = ((mag <<< 14) + (m >>> 1)) / m;
      else          q = (mag + 4096) >>> 13;
      s[i] = 16'(w[i] < 0 ? -q : q);
    end
    r.fl = s[0]; r.fr = s[1]; r.rl = s[2]; r.rr = s[3];
    return r;
  endfunction

  function automatic drive_cmd_t mk(logic op, int x, int y, int rad, int th, int z, int g);
    drive_cmd_t c;
    c.op = op; c.x = 16'(x); c.y = 16'(y); c.radius = 16'(rad);
    c.theta = 16'(th); c.rot = 16'(z); c.gyro = 16'(g);
    return c;
  endfunction

  function automatic wheel_set_t ws(int fl, int fr, int rl, int rr, logic sc);
    wheel_set_t r;
    r.fl = 16'(fl); r.fr = 16'(fr); r.rl = 16'(rl); r.rr = 16'(rr); r.scaled = sc;
    return r;
  endfunction

  // Random command: mostly moderate values, sometimes full range, angles near fold edges.
  function automatic drive_cmd_t rand_cmd();
    drive_cmd_t c;
    int sel;
    c.op = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 3);
    c.x = (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
    c.y = (sel == 1) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
    c.radius = (sel == 2) ? 16'($urandom) : 16'($urandom_range(0, 16384) - 8192);
    c.rot = (sel == 3) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
    c.theta = 16'($urandom);
    c.gyro = 16'($urandom);
    if ($urandom_range(0, 7) == 0) c.theta = 16'(16384 * $urandom_range(0, 3) +
                                                 $urandom_range(0, 4) - 2);
    if ($urandom_range(0, 7) == 0) c.gyro = 16'(16384 * $urandom_range(0, 3) +
                                                $urandom_range(0, 4) - 2);
    return c;
  endfunction

  // Present one command, hold it until transfer, then record the expected wheels.
  task automatic send_cmd(input drive_cmd_t c, input wheel_set_t want);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= c.op;
    x_cmd_i        <= c.x;
    y_cmd_i        <= c.y;
    radius_cmd_i   <= c.radius;
    theta_angle_i  <= c.theta;
    rotation_cmd_i <= c.rot;
    gyro_angle_i   <= c.gyro;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    wheel_queue.push_back(want);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: check every result transfer, then pick the next ready value.
  initial begin
    wheel_set_t want, got;
    int stall_left, run_left;
    bit pressed;
    stall_left = 0; run_left = 0; pressed = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = ws(front_left_speed_o, front_right_speed_o, rear_left_speed_o,
                 rear_right_speed_o, was_scaled_o);
        if (wheel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = wheel_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"wheel mismatch: expected fl=%0d fr=%0d rl=%0d rr=%0d sc=%0b,",
                        " got fl=%0d fr=%0d rl=%0d rr=%0d sc=%0b"},
                       want.fl, want.fr, want.rl, want.rr, want.scaled,
                       got.fl, got.fr, got.rl, got.rr, got.scaled);
          end
        end
      end
      // hold off long once so the pipeline fills and stalls its input
      if (press_req && !pressed) begin
        pressed = 1;
        stall_left = PRESS_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && run_left == 0 && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) run_left = $urandom_range(1, 40);
        run_left--;
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    stim_row_t rows[$];
    drive_cmd_t c;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_CART;
    x_cmd_i = '0; y_cmd_i = '0; radius_cmd_i = '0;
    theta_angle_i = '0; rotation_cmd_i = '0; gyro_angle_i = '0;

    // zero command, pure rotation at exactly 1.0 and at the extremes
    rows.push_back('{mk(OP_CART, 0, 0, 0, 0, 0, 0), 1'b1, ws(0, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_POLAR, 0, 0, 0, 0, 0, 0), 1'b1, ws(0, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_CART, 0, 0, 0, 0, 8192, 0), 1'b1,
                     ws(16384, -16384, 16384, -16384, 0)});
    rows.push_back('{mk(OP_CART, 0, 0, 0, 0, -8192, 0), 1'b1,
                     ws(-16384, 16384, -16384, 16384, 0)});
    rows.push_back('{mk(OP_CART, 0, 0, 0, 0, -32768, 0), 1'b1,
                     ws(-16384, 16384, -16384, 16384, 1)});
    rows.push_back('{mk(OP_POLAR, 0, 0, 0, 0, 32767, 0), 1'b1,
                     ws(16384, -16384, 16384, -16384, 1)});
    // polar mode ignores x, y, gyro; cartesian ignores radius, theta
    rows.push_back('{mk(OP_POLAR, 32767, -32768, 0, 12345, 100, 65535), 1'b1,
                     ws(200, -200, 200, -200, 0)});
    rows.push_back('{mk(OP_CART, 0, 0, 32767, 65535, -100, 0), 1'b1,
                     ws(-200, 200, -200, 200, 0)});
    rows.push_back('{mk(OP_CART, 32767, 32767, 0, 0, 32767, 0), 1'b0, '0});
    rows.push_back('{mk(OP_CART, -32768, -32768, 0, 0, -32768, 65535), 1'b0, '0});
    rows.push_back('{mk(OP_CART, 8192, 0, 0, 0, 0, 32768), 1'b0, '0});
    rows.push_back('{mk(OP_CART, 4096, -4096, 0, 0, 0, 16384), 1'b0, '0});
    rows.push_back('{mk(OP_CART, 4096, 4096, 0, 0, 0, 16385), 1'b0, '0});
    rows.push_back('{mk(OP_CART, -4096, 2048, 0, 0, 1000, 49151), 1'b0, '0});
    rows.push_back('{mk(OP_POLAR, 0, 0, 8192, 32768, 0, 0), 1'b0, '0});
    rows.push_back('{mk(OP_POLAR, 0, 0, 8192, 16384, 0, 0), 1'b0, '0});
    rows.push_back('{mk(OP_POLAR, 0, 0, -32768, 16385, 0, 0), 1'b0, '0});
    rows.push_back('{mk(OP_POLAR, 0, 0, 32767, 49152, 2048, 0), 1'b0, '0});
    rows.push_back('{mk(OP_POLAR, 0, 0, 4096, 8192, -4096, 0), 1'b0, '0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_cmd(rows[i].cmd, rows[i].typed ? rows[i].want : mix_wheels(rows[i].cmd));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PRESS_AT) press_req = 1;
      if (n == QUIET_FROM) quiet = 1;
      c = rand_cmd();
      send_cmd(c, mix_wheels(c));
    end
    in_valid_i <= 1'b0;

    // drain: wait for every result, then report the verdict
    while (wheel_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== mecanum_wheel_mixer.f =====
rtl/mwm_pkg.sv
rtl/mwm_cordic_cell.sv
rtl/mwm_div_cell.sv
rtl/mecanum_wheel_mixer.sv
test/tb_mecanum_wheel_mixer.sv
